// File: design/pqms_pkg.sv
// Shared types and constants for the max-scan priority queue.
// No dependencies; imported by every module in the design folder.
`default_nettype none

package pqms_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PRIO_W     = 16;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_PULL   = 2'd1;
    localparam logic [1:0] MODE_PEEK   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] data;
        logic [PRIO_W-1:0]     prio;
    } t_entry;

    typedef struct packed {
        logic start;       // word accepted: latch status, do insert, begin scan read
        logic scan;        // compare one entry, fetch the next
        logic shift_init;  // last scan cycle of a pull: point at entry after winner
        logic shift;       // move one entry down
        logic dec;         // removal finished
        logic load_out;    // copy result into output register
    } t_dp_cmd;

    typedef struct packed {
        logic is_empty;
        logic is_full;
        logic scan_last;
        logic shift_done;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: design/pqms_datapath.sv
// Datapath: entry memory, count, max search registers and output register.
// Depends on pqms_pkg; driven by pqms_ctrl through t_dp_cmd.
`default_nettype none

module pqms_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pqms_pkg::t_dp_cmd  i_cmd,
    output pqms_pkg::t_dp_stat      o_stat,
    input  wire logic [1:0]         i_mode,
    input  wire logic [31:0]        i_data_in,
    input  wire logic [15:0]        i_priority_in,
    output logic [31:0]             o_data_out,
    output logic [1:0]              o_status,
    output logic [4:0]              o_entry_count
);
    import pqms_pkg::*;

    t_entry                r_mem [DEPTH];
    t_entry                r_rd;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [IDX_W-1:0]      rd_addr;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_ptr;
    logic                  r_wr_vld;
    logic [1:0]            r_status;
    logic [DATA_WIDTH-1:0] r_best_data;
    logic [PRIO_W-1:0]     r_best_prio;
    logic [IDX_W-1:0]      r_best_idx;
    logic [IDX_W-1:0]      n_best_idx;

    logic [31:0]           r_out_data;
    logic [1:0]            r_out_status;
    logic [4:0]            r_out_count;

    logic is_search;
    logic take;
    logic issue;
    logic do_insert;

    assign is_search = (i_mode == MODE_PULL) || (i_mode == MODE_PEEK);
    assign do_insert = i_cmd.start && (i_mode == MODE_INSERT) && !o_stat.is_full;

    // first held entry always wins, later ones only on strictly larger priority
    assign take       = (r_rd_idx == '0) || (r_rd.prio > r_best_prio);
    assign n_best_idx = take ? r_rd_idx : r_best_idx;
    assign issue      = (r_ptr < r_count);
    assign rd_addr    = i_cmd.start ? '0 : r_ptr[IDX_W-1:0];

    always_comb begin
        o_stat.is_empty   = (r_count == '0);
        o_stat.is_full    = (r_count >= CNT_W'(DEPTH));
        o_stat.scan_last  = (CNT_W'(r_rd_idx) == (r_count - CNT_W'(1)));
        o_stat.shift_done = !issue && !r_wr_vld;
    end

    // memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (do_insert) begin
            r_mem[r_count[IDX_W-1:0]] <= t_entry'{data: DATA_WIDTH'(i_data_in),
                                                  prio: i_priority_in};
        end else if (i_cmd.shift && r_wr_vld) begin
            r_mem[r_rd_idx - IDX_W'(1)] <= r_rd;
        end
        r_rd     <= r_mem[rd_addr];
        r_rd_idx <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_vld <= 1'b0;
        end else begin
            if (do_insert) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.shift_init) begin
                r_wr_vld <= 1'b0;
            end else if (i_cmd.shift) begin
                r_wr_vld <= issue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ptr       <= CNT_W'(1);
            r_best_data <= '0;
            if ((i_mode == MODE_INSERT) && o_stat.is_full) begin
                r_status <= ST_FULL;
            end else if (is_search && o_stat.is_empty) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
        end else if (i_cmd.scan) begin
            if (i_cmd.shift_init) begin
                r_ptr <= CNT_W'(n_best_idx) + CNT_W'(1);
            end else begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
            if (take) begin
                r_best_data <= r_rd.data;
                r_best_prio <= r_rd.prio;
                r_best_idx  <= r_rd_idx;
            end
        end else if (i_cmd.shift && issue) begin
            r_ptr <= r_ptr + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data   <= 32'(r_best_data);
            r_out_status <= r_status;
            r_out_count  <= 5'(r_count);
        end
    end

    assign o_data_out    = r_out_data;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_insert |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not bump count");

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift |-> !i_cmd.start)
        else $error("insert during removal shift");

endmodule

`default_nettype wire

// File: design/pqms_ctrl.sv
// Controller: sequences insert, max scan, removal shift and result handoff.
// Depends on pqms_pkg; commands pqms_datapath through t_dp_cmd.
`default_nettype none

module pqms_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_mode,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output pqms_pkg::t_dp_cmd       o_cmd,
    input  wire pqms_pkg::t_dp_stat i_stat
);
    import pqms_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_op;
    logic       r_out_valid, n_out_valid;
    logic       accept_in;
    logic       out_free;

    assign o_stall   = (r_state != S_IDLE);
    assign accept_in = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign o_valid   = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    if (((i_mode == MODE_PULL) || (i_mode == MODE_PEEK)) && !i_stat.is_empty) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = (r_op == MODE_PULL) ? S_SHIFT : S_DONE;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:  o_cmd.start = accept_in;
            S_SCAN: begin
                o_cmd.scan       = 1'b1;
                o_cmd.shift_init = i_stat.scan_last && (r_op == MODE_PULL);
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                o_cmd.dec   = i_stat.shift_done;
            end
            S_DONE:  o_cmd.load_out = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= MODE_INSERT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (accept_in) begin
                r_op <= i_mode;
            end
        end
    end

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word raised outside done state");

    a_shift_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) && ($past(r_state) != S_SHIFT) |-> $past(o_cmd.shift_init))
        else $error("shift entered without scan end");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.start, o_cmd.scan, o_cmd.shift, o_cmd.load_out}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// File: design/priority_queue_max_scan.sv
// Max-scan priority queue, top level: joins pqms_ctrl and pqms_datapath.
// Depends on pqms_pkg, pqms_ctrl, pqms_datapath.
//
// Input channel: i_valid / o_stall with i_mode, i_data_in, i_priority_in.
// Output channel: o_valid / i_stall with o_data_out, o_status, o_entry_count.
// Every input word gives exactly one output word.
// Insert, no-op, or pull/peek on an empty queue go straight to the done state;
// peek scans every held entry; pull scans them all and then moves each entry
// behind the winner down by one.
// The single read port of the entry memory sets this pace: the search reads
// one entry per cycle, and the removal moves one entry down per cycle.
// One word is in work at a time; a new word is taken once the previous
// result sits in the output register, even while the receiver stalls it.
// A stalled result holds until taken; the next result waits behind it.
// Reset (i_rst_n low, synchronous) empties the queue; no memory clearing.
`default_nettype none

module priority_queue_max_scan (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_data_in,
    input  wire logic [15:0] i_priority_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_data_out,
    output logic [1:0]       o_status,
    output logic [4:0]       o_entry_count
);
    import pqms_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pqms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_mode  (i_mode),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    pqms_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_mode        (i_mode),
        .i_data_in     (i_data_in),
        .i_priority_in (i_priority_in),
        .o_data_out    (o_data_out),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire
